// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level parser RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define NGGA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ngga check failed");

// Property checked on every clock edge, reset cycles included.
`define NGGA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ngga check failed");

`endif

// ----- hdl/ngga_pkg.sv -----
// ----------------------------------------------------------------------------
// ngga_pkg
// Types and constants shared by the GGA position parser front end, queue and
// conversion pipeline.
// ----------------------------------------------------------------------------
package ngga_pkg;

  // Field widths.
  localparam int WHOLE_W = 17;
  localparam int FRAC_W  = 14;
  localparam int DIGS_W  = 3;
  localparam int COORD_W = 31;
  localparam int MAG_W   = 30;

  // Character codes.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ABORT = 8'hFF;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Scanner limits and codes.
  localparam logic [WHOLE_W-1:0] WHOLE_MAX       = 17'd99999;
  localparam logic [DIGS_W-1:0]  FRAC_MAX_DIGITS = 3'd4;
  localparam logic [DIGS_W-1:0]  REJECT_CODE     = 3'd7;
  localparam logic [2:0]         HDR_LEN         = 3'd6;
  localparam logic [3:0]         FIELD_MAX       = 4'd15;
  localparam logic [3:0]         FIELD_HDR       = 4'd0;
  localparam logic [3:0]         FIELD_LAT       = 4'd2;
  localparam logic [3:0]         FIELD_LAT_DIR   = 4'd3;
  localparam logic [3:0]         FIELD_LON       = 4'd4;
  localparam logic [3:0]         FIELD_LON_DIR   = 4'd5;

  // Direction field status codes.
  localparam logic [1:0] DIR_EMPTY = 2'd0;
  localparam logic [1:0] DIR_NEG   = 2'd1;
  localparam logic [1:0] DIR_OTHER = 2'd2;
  localparam logic [1:0] DIR_LONG  = 2'd3;

  // Coordinate scan phases.
  typedef enum logic [3:0] {
    PH_WAIT  = 4'b0001,
    PH_WHOLE = 4'b0010,
    PH_FRAC  = 4'b0100,
    PH_DONE  = 4'b1000
  } scan_phase_t;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // Reciprocal multipliers for the constant divisions by 100 and by 3.
  localparam logic [15:0] DIV100_MUL   = 16'd41943;
  localparam int          DIV100_SHIFT = 22;
  localparam logic [23:0] DIV3_MUL     = 24'd11184811;
  localparam int          DIV3_SHIFT   = 25;

  // One scanned coordinate as handed to the conversion pipeline.
  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic [DIGS_W-1:0]  digs;
    logic               present;
    logic               neg;
  } coord_rec_t;

  // One finished GGA line.
  typedef struct packed {
    coord_rec_t lat;
    coord_rec_t lon;
  } line_rec_t;

  // Characters of the sentence tag "$GPGGA", by position.
  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h47;
      3'd4:    ch = 8'h47;
      3'd5:    ch = 8'h41;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/ngga_front.sv -----
// ----------------------------------------------------------------------------
// ngga_front
// Byte scanner: splits lines and fields, matches the sentence tag and gathers
// the digits of both coordinates. Hands one record per GGA line to the queue.
// ----------------------------------------------------------------------------
module ngga_front import ngga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output line_rec_t  push_rec
);

  logic [3:0]         field_number, field_number_next;
  logic [2:0]         header_progress, header_progress_next;
  logic               header_mismatch, header_mismatch_next;
  logic               line_has_text, line_has_text_next;
  logic [WHOLE_W-1:0] coord_whole [2];
  logic [WHOLE_W-1:0] coord_whole_next [2];
  logic [FRAC_W-1:0]  coord_fraction [2];
  logic [FRAC_W-1:0]  coord_fraction_next [2];
  logic [DIGS_W-1:0]  coord_fraction_digits [2];
  logic [DIGS_W-1:0]  coord_fraction_digits_next [2];
  scan_phase_t        coord_scan_phase [2];
  scan_phase_t        coord_scan_phase_next [2];
  logic [1:0]         direction_status [2];
  logic [1:0]         direction_status_next [2];
  coord_rec_t         rec [2];

  // Record of the current line, taken when its newline arrives.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rec[k].whole   = coord_whole[k];
      rec[k].frac    = coord_fraction[k];
      rec[k].digs    = coord_fraction_digits[k];
      rec[k].present = (coord_scan_phase[k] != PH_WAIT) &&
                       (coord_fraction_digits[k] != REJECT_CODE);
      rec[k].neg     = (direction_status[k] == DIR_NEG);
    end
    push_rec.lat = rec[0];
    push_rec.lon = rec[1];
  end

  // Next state of the scanner for one accepted byte.
  always_comb begin
    logic               is_digit;
    logic [3:0]         dval;
    logic [19:0]        grown;
    logic               clear;
    is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    dval     = rx_byte[3:0];
    grown    = '0;
    clear    = 1'b0;
    push     = 1'b0;

    field_number_next    = field_number;
    header_progress_next = header_progress;
    header_mismatch_next = header_mismatch;
    line_has_text_next   = line_has_text;
    for (int k = 0; k < 2; k++) begin
      coord_whole_next[k]           = coord_whole[k];
      coord_fraction_next[k]        = coord_fraction[k];
      coord_fraction_digits_next[k] = coord_fraction_digits[k];
      coord_scan_phase_next[k]      = coord_scan_phase[k];
      direction_status_next[k]      = direction_status[k];
    end

    if (accept) begin
      if (rx_byte == CH_ABORT) begin
        clear = 1'b1;
      end else if (rx_byte == CH_LF) begin
        push  = line_has_text && !header_mismatch && (header_progress == HDR_LEN);
        clear = 1'b1;
      end else if (rx_byte == CH_COMMA) begin
        line_has_text_next = 1'b1;
        if ((field_number == FIELD_HDR) && (header_progress != HDR_LEN)) begin
          header_mismatch_next = 1'b1;
        end
        if (field_number < FIELD_MAX) begin
          field_number_next = field_number + 4'd1;
        end
      end else begin
        line_has_text_next = 1'b1;

        // Sentence tag in the first field.
        if (field_number == FIELD_HDR) begin
          if ((header_progress < HDR_LEN) && (rx_byte == tag_char(header_progress))) begin
            header_progress_next = header_progress + 3'd1;
          end else begin
            header_mismatch_next = 1'b1;
          end
        end

        for (int k = 0; k < 2; k++) begin
          // Coordinate digits.
          if (field_number == ((k == 0) ? FIELD_LAT : FIELD_LON)) begin
            unique case (coord_scan_phase[k])
              PH_WAIT: begin
                if (is_digit) begin
                  coord_whole_next[k]      = WHOLE_W'(dval);
                  coord_scan_phase_next[k] = PH_WHOLE;
                end else begin
                  coord_fraction_digits_next[k] = REJECT_CODE;
                  coord_scan_phase_next[k]      = PH_DONE;
                end
              end
              PH_WHOLE: begin
                if (is_digit) begin
                  grown = 20'(coord_whole[k]) * 20'd10 + 20'(dval);
                  coord_whole_next[k] = (grown > 20'(WHOLE_MAX)) ? WHOLE_MAX
                                                                 : grown[WHOLE_W-1:0];
                end else if (rx_byte == CH_POINT) begin
                  coord_scan_phase_next[k] = PH_FRAC;
                end else begin
                  coord_scan_phase_next[k] = PH_DONE;
                end
              end
              PH_FRAC: begin
                if (is_digit) begin
                  if (coord_fraction_digits[k] < FRAC_MAX_DIGITS) begin
                    coord_fraction_next[k] =
                      FRAC_W'(coord_fraction[k] * 14'd10 + FRAC_W'(dval));
                    coord_fraction_digits_next[k] = coord_fraction_digits[k] + 3'd1;
                  end
                end else begin
                  coord_scan_phase_next[k] = PH_DONE;
                end
              end
              default: begin
              end
            endcase
          end

          // Direction letter.
          if (field_number == ((k == 0) ? FIELD_LAT_DIR : FIELD_LON_DIR)) begin
            if (direction_status[k] == DIR_EMPTY) begin
              direction_status_next[k] = ((rx_byte == CH_S) || (rx_byte == CH_W)) ?
                                         DIR_NEG : DIR_OTHER;
            end else begin
              direction_status_next[k] = DIR_LONG;
            end
          end
        end
      end
    end

    // Line end or abort starts a fresh line.
    if (clear) begin
      field_number_next    = '0;
      header_progress_next = '0;
      header_mismatch_next = 1'b0;
      line_has_text_next   = 1'b0;
      for (int k = 0; k < 2; k++) begin
        coord_whole_next[k]           = '0;
        coord_fraction_next[k]        = '0;
        coord_fraction_digits_next[k] = '0;
        coord_scan_phase_next[k]      = PH_WAIT;
        direction_status_next[k]      = DIR_EMPTY;
      end
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_number    <= '0;
      header_progress <= '0;
      header_mismatch <= 1'b0;
      line_has_text   <= 1'b0;
      for (int k = 0; k < 2; k++) begin
        coord_whole[k]           <= '0;
        coord_fraction[k]        <= '0;
        coord_fraction_digits[k] <= '0;
        coord_scan_phase[k]      <= PH_WAIT;
        direction_status[k]      <= DIR_EMPTY;
      end
    end else begin
      field_number    <= field_number_next;
      header_progress <= header_progress_next;
      header_mismatch <= header_mismatch_next;
      line_has_text   <= line_has_text_next;
      for (int k = 0; k < 2; k++) begin
        coord_whole[k]           <= coord_whole_next[k];
        coord_fraction[k]        <= coord_fraction_next[k];
        coord_fraction_digits[k] <= coord_fraction_digits_next[k];
        coord_scan_phase[k]      <= coord_scan_phase_next[k];
        direction_status[k]      <= direction_status_next[k];
      end
    end
  end

endmodule

// ----- hdl/ngga_queue.sv -----
// ----------------------------------------------------------------------------
// ngga_queue
// Small first-in first-out queue of line records between the byte scanner
// and the conversion pipeline. Read data is registered.
// ----------------------------------------------------------------------------
module ngga_queue import ngga_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  line_rec_t push_rec,
  input  logic      pop,
  output logic      full,
  output logic      empty,
  output line_rec_t rd_rec
);

  line_rec_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_CW-1:0]   count;

  assign full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count == '0);

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
    if (pop) begin
      rd_rec <= mem[rd_ptr];
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

endmodule

// ----- hdl/ngga_conv.sv -----
// ----------------------------------------------------------------------------
// ngga_conv
// Conversion pipeline: turns the scanned ddmm.mmmm digits of both
// coordinates into signed microdegrees and holds the result for the receiver.
// ----------------------------------------------------------------------------
module ngga_conv import ngga_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  line_rec_t                 q_rec,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] latitude,
  output logic signed [COORD_W-1:0] longitude,
  output logic                      latitude_present,
  output logic                      longitude_present
);

  logic                      advance;
  logic                      v0, s1_v, s2_v, s3_v, s4_v;
  coord_rec_t                in_rec [2];

  // Stage registers, one lane per coordinate.
  logic [WHOLE_W-1:0]        s1_whole [2];
  logic [10:0]               s1_qest [2];
  logic [FRAC_W-1:0]         s1_scaled [2];
  logic                      s1_present [2];
  logic                      s1_neg [2];
  logic [9:0]                s2_deg [2];
  logic [6:0]                s2_mins [2];
  logic [FRAC_W-1:0]         s2_scaled [2];
  logic                      s2_present [2];
  logic                      s2_neg [2];
  logic [9:0]                s3_deg [2];
  logic [22:0]               s3_m5 [2];
  logic                      s3_present [2];
  logic                      s3_neg [2];
  logic [9:0]                s4_deg [2];
  logic [20:0]               s4_quot [2];
  logic                      s4_present [2];
  logic                      s4_neg [2];
  logic [COORD_W-1:0]        res [2];

  // Stage logic values.
  logic [10:0]               c1_qest [2];
  logic [FRAC_W-1:0]         c1_scaled [2];
  logic [9:0]                c2_deg [2];
  logic [6:0]                c2_mins [2];
  logic [22:0]               c3_m5 [2];
  logic [20:0]               c4_quot [2];
  logic [COORD_W-1:0]        c5_res [2];

  // The whole pipeline moves when the output register is free or being taken.
  assign advance = !out_valid || !out_stall;
  assign pop     = advance && !q_empty;

  assign in_rec[0] = q_rec.lat;
  assign in_rec[1] = q_rec.lon;

  always_comb begin
    logic [32:0] prod_q;
    logic [17:0] rem;
    logic [19:0] minutes;
    logic [47:0] prod_d;
    logic [MAG_W-1:0] mag;
    for (int k = 0; k < 2; k++) begin
      // Degrees estimate by reciprocal of 100; fraction scaled to four digits.
      prod_q     = 33'(in_rec[k].whole) * 33'(DIV100_MUL);
      c1_qest[k] = 11'(prod_q >> DIV100_SHIFT);
      unique case (in_rec[k].digs)
        3'd0:    c1_scaled[k] = '0;
        3'd1:    c1_scaled[k] = FRAC_W'(in_rec[k].frac * 14'd1000);
        3'd2:    c1_scaled[k] = FRAC_W'(in_rec[k].frac * 14'd100);
        3'd3:    c1_scaled[k] = FRAC_W'(in_rec[k].frac * 14'd10);
        default: c1_scaled[k] = in_rec[k].frac;
      endcase

      // Correct the estimate; the remainder is whole minutes.
      rem = 18'(s1_whole[k]) - 18'(s1_qest[k]) * 18'd100;
      if (rem >= 18'd100) begin
        c2_deg[k]  = 10'(s1_qest[k] + 11'd1);
        c2_mins[k] = 7'(rem - 18'd100);
      end else begin
        c2_deg[k]  = 10'(s1_qest[k]);
        c2_mins[k] = 7'(rem);
      end

      // Minutes in 1/10000 units, times 5 (100/60 = 5/3).
      minutes  = 20'(s2_mins[k]) * 20'd10000 + 20'(s2_scaled[k]);
      c3_m5[k] = 23'(minutes) * 23'd5;

      // Divide by 3 through the reciprocal.
      prod_d     = 48'(s3_m5[k]) * 48'(DIV3_MUL);
      c4_quot[k] = 21'(prod_d >> DIV3_SHIFT);

      // Magnitude, sign and the absent case.
      mag = 30'(s4_deg[k]) * 30'd1000000 + 30'(s4_quot[k]);
      if (!s4_present[k]) begin
        c5_res[k] = '0;
      end else if (s4_neg[k]) begin
        c5_res[k] = COORD_W'(31'd0 - {1'b0, mag});
      end else begin
        c5_res[k] = {1'b0, mag};
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v0        <= pop;
      s1_v      <= v0;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      out_valid <= s4_v;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 2; k++) begin
        s1_whole[k]   <= in_rec[k].whole;
        s1_qest[k]    <= c1_qest[k];
        s1_scaled[k]  <= c1_scaled[k];
        s1_present[k] <= in_rec[k].present;
        s1_neg[k]     <= in_rec[k].neg;
        s2_deg[k]     <= c2_deg[k];
        s2_mins[k]    <= c2_mins[k];
        s2_scaled[k]  <= s1_scaled[k];
        s2_present[k] <= s1_present[k];
        s2_neg[k]     <= s1_neg[k];
        s3_deg[k]     <= s2_deg[k];
        s3_m5[k]      <= c3_m5[k];
        s3_present[k] <= s2_present[k];
        s3_neg[k]     <= s2_neg[k];
        s4_deg[k]     <= s3_deg[k];
        s4_quot[k]    <= c4_quot[k];
        s4_present[k] <= s3_present[k];
        s4_neg[k]     <= s3_neg[k];
        res[k]        <= c5_res[k];
      end
      latitude_present  <= s4_present[0];
      longitude_present <= s4_present[1];
    end
  end

  assign latitude  = $signed(res[0]);
  assign longitude = $signed(res[1]);

endmodule

// ----- hdl/nmea_gga_position_parser.sv -----
// ----------------------------------------------------------------------------
// nmea_gga_position_parser
// Parses a stream of NMEA characters and reports GGA latitude and longitude
// in signed microdegrees.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character per transaction on rx_byte, qualified by
//   in_valid and in_stall. A newline ends a line, 0xFF discards it.
//   Output channel: one transaction per $GPGGA line, carrying latitude,
//   longitude and their present flags, qualified by out_valid and out_stall.
//   Throughput: one character per cycle. The input stalls only when the
//   four-entry line queue is full, which takes four GGA lines piling up
//   behind a stalled receiver.
//   Path: the result is registered through the queue read register and
//   the five-stage conversion pipeline (divide by 100, correction, minutes
//   times 5, divide by 3, scale and sign).
//   Reset clears the scanner, the queue and all pipeline valid bits; the
//   first line after reset is parsed from its first character.
//   While the receiver stalls, the held result stays on the output and the
//   pipeline freezes; characters keep being taken until the queue fills.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nmea_gga_position_parser import ngga_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] latitude,
  output logic signed [COORD_W-1:0] longitude,
  output logic                      latitude_present,
  output logic                      longitude_present
);

  logic      accept;
  logic      q_push;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;
  line_rec_t push_rec;
  line_rec_t q_rec;
  logic      lat_absent_ok;
  logic      lon_absent_ok;

  // Input transactions wait only while the queue is full.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  ngga_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .push     (q_push),
    .push_rec (push_rec)
  );

  ngga_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .rd_rec   (q_rec)
  );

  ngga_conv u_conv (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_rec             (q_rec),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .latitude          (latitude),
    .longitude         (longitude),
    .latitude_present  (latitude_present),
    .longitude_present (longitude_present)
  );

  // A coordinate is either present or reads as zero.
  assign lat_absent_ok = latitude_present || (latitude == '0);
  assign lon_absent_ok = longitude_present || (longitude == '0);

  // A line record is never written into a full queue.
  `NGGA_ASSERT(a_push_not_full, q_push |-> !q_full)
  // An absent coordinate is reported as zero.
  `NGGA_ASSERT(a_absent_zero, out_valid |-> lat_absent_ok && lon_absent_ok)
  // The reported latitude stays within the largest magnitude the digits can give.
  `NGGA_ASSERT(a_lat_range, out_valid |-> (latitude <= 31'sd1000666665) && (latitude >= -31'sd1000666665))
  // Reset is followed by no valid result and no line push.
  `NGGA_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && !q_push)

endmodule
